/* hdl/mgs_pkg.sv */
// ----------------------------------------------------------------------------
// mgs_pkg
// Shared item types and fixed widths for the motion grid score block.
// ----------------------------------------------------------------------------
package mgs_pkg;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 9;
  localparam int SUM_W      = 32;
  localparam int CELLS_W    = 8;
  localparam int QUOT_W     = 32;

  localparam logic [POS_W-1:0] POS_MAX           = 9'd511;
  localparam logic [POS_W-1:0] FRAME_WIDTH_RESET = 9'd320;
  localparam logic [SUM_W-1:0] SUM_MAX           = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last_of_frame;
  } pixel_item_t;

  typedef struct packed {
    logic [CELLS_W-1:0] cells_with_motion;
    logic [QUOT_W-1:0]  motion_score;
  } score_item_t;

endpackage

/* hdl/mgs_pos.sv */
// ----------------------------------------------------------------------------
// mgs_pos
// Raster position tracker: column/row plus incremental grid cell coordinates.
// ----------------------------------------------------------------------------
module mgs_pos #(
  parameter int CELLS_WIDE = 16,
  parameter int CELLS_HIGH = 12,
  parameter int CELL_SIZE  = 20,
  localparam int TOTAL     = CELLS_WIDE * CELLS_HIGH,
  localparam int IDX_W     = (TOTAL > 1) ? $clog2(TOTAL) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     item_fire,
  input  logic                     item_last,
  input  logic [mgs_pkg::POS_W-1:0] frame_width,
  output logic                     loc_in_grid,
  output logic [IDX_W-1:0]         loc_idx
);

  localparam int SUB_W = (CELL_SIZE > 1) ? $clog2(CELL_SIZE) : 1;
  localparam int CX_W  = $clog2(CELLS_WIDE + 1);
  localparam int CY_W  = $clog2(CELLS_HIGH + 1);
  localparam int PW    = mgs_pkg::POS_W;

  logic [PW-1:0]    column_r, column_nxt;
  logic [PW-1:0]    row_r, row_nxt;
  logic [SUB_W-1:0] sub_x_r, sub_x_nxt;
  logic [SUB_W-1:0] sub_y_r, sub_y_nxt;
  logic [CX_W-1:0]  cell_x_r, cell_x_nxt;
  logic [CY_W-1:0]  cell_y_r, cell_y_nxt;

  logic row_wrap;
  logic sub_x_end;
  logic sub_y_end;

  assign loc_in_grid = (cell_x_r < CX_W'(CELLS_WIDE)) && (cell_y_r < CY_W'(CELLS_HIGH));
  // index arithmetic wraps harmlessly in IDX_W bits: in-grid values stay below TOTAL
  assign loc_idx = loc_in_grid ?
                   IDX_W'(IDX_W'(cell_y_r) * IDX_W'(CELLS_WIDE) + IDX_W'(cell_x_r)) : '0;

  assign row_wrap  = ({1'b0, column_r} + (PW+1)'(1)) >= {1'b0, frame_width};
  assign sub_x_end = (sub_x_r == SUB_W'(CELL_SIZE - 1));
  assign sub_y_end = (sub_y_r == SUB_W'(CELL_SIZE - 1));

  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    sub_x_nxt  = sub_x_r;
    sub_y_nxt  = sub_y_r;
    cell_x_nxt = cell_x_r;
    cell_y_nxt = cell_y_r;
    if (item_last) begin
      column_nxt = '0;
      row_nxt    = '0;
      sub_x_nxt  = '0;
      sub_y_nxt  = '0;
      cell_x_nxt = '0;
      cell_y_nxt = '0;
    end else if (row_wrap) begin
      column_nxt = '0;
      sub_x_nxt  = '0;
      cell_x_nxt = '0;
      // row sticks at its maximum, and so does its cell
      if (row_r != mgs_pkg::POS_MAX) begin
        row_nxt = row_r + PW'(1);
        if (sub_y_end) begin
          sub_y_nxt = '0;
          if (cell_y_r != CY_W'(CELLS_HIGH)) begin
            cell_y_nxt = cell_y_r + CY_W'(1);
          end
        end else begin
          sub_y_nxt = sub_y_r + SUB_W'(1);
        end
      end
    end else begin
      column_nxt = column_r + PW'(1);
      if (sub_x_end) begin
        sub_x_nxt = '0;
        // hold at one past the grid edge
        if (cell_x_r != CX_W'(CELLS_WIDE)) begin
          cell_x_nxt = cell_x_r + CX_W'(1);
        end
      end else begin
        sub_x_nxt = sub_x_r + SUB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
      sub_x_r  <= '0;
      sub_y_r  <= '0;
      cell_x_r <= '0;
      cell_y_r <= '0;
    end else if (item_fire) begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      sub_x_r  <= sub_x_nxt;
      sub_y_r  <= sub_y_nxt;
      cell_x_r <= cell_x_nxt;
      cell_y_r <= cell_y_nxt;
    end
  end

endmodule

/* hdl/mgs_accum.sv */
// ----------------------------------------------------------------------------
// mgs_accum
// Input register, per-cell motion marks, marked-cell count and saturating sum.
// ----------------------------------------------------------------------------
module mgs_accum #(
  parameter int CELLS_WIDE = 16,
  parameter int CELLS_HIGH = 12,
  localparam int TOTAL     = CELLS_WIDE * CELLS_HIGH,
  localparam int IDX_W     = (TOTAL > 1) ? $clog2(TOTAL) : 1,
  localparam int CNT_W     = $clog2(TOTAL + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mgs_pkg::pixel_item_t      in_data,
  input  logic                      loc_in_grid,
  input  logic [IDX_W-1:0]          loc_idx,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [mgs_pkg::SUM_W-1:0] res_sum,
  output logic [CNT_W-1:0]          res_count
);

  localparam int SW = mgs_pkg::SUM_W;

  logic                       p_valid_r;
  logic [mgs_pkg::PIX_W-1:0]  p_pixel_r;
  logic                       p_last_r;
  logic                       p_in_grid_r;
  logic [IDX_W-1:0]           p_idx_r;

  logic [TOTAL-1:0] mark_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SW-1:0]    sum_r;

  logic             fire_p;
  logic             mark_hit;
  logic [CNT_W-1:0] cnt_nxt;
  logic [SW:0]      sum_wide;
  logic [SW-1:0]    sum_nxt;

  // only a last pixel can wait, and only on the scoring pipeline
  assign fire_p   = p_valid_r && (!p_last_r || res_ready);
  assign in_ready = !p_valid_r || fire_p;

  assign mark_hit = p_in_grid_r && (p_pixel_r != '0) && !mark_r[p_idx_r];
  assign cnt_nxt  = cnt_r + CNT_W'(mark_hit);
  assign sum_wide = {1'b0, sum_r} + (SW+1)'(p_pixel_r);
  assign sum_nxt  = sum_wide[SW] ? mgs_pkg::SUM_MAX : sum_wide[SW-1:0];

  assign res_valid = p_valid_r && p_last_r;
  assign res_sum   = sum_nxt;
  assign res_count = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_ready) begin
      p_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      p_pixel_r   <= in_data.pixel;
      p_last_r    <= in_data.last_of_frame;
      p_in_grid_r <= loc_in_grid;
      p_idx_r     <= loc_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
    end else if (fire_p) begin
      if (p_last_r) begin
        // frame done: its totals leave on res_*, start over
        mark_r <= '0;
        cnt_r  <= '0;
        sum_r  <= '0;
      end else begin
        cnt_r <= cnt_nxt;
        sum_r <= sum_nxt;
        if (mark_hit) begin
          mark_r[p_idx_r] <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/mgs_score.sv */
// ----------------------------------------------------------------------------
// mgs_score
// Score pipeline: split the sum by the cell count with a reciprocal multiply,
// scale quotient and remainder by the unmarked cells, add into the output.
// ----------------------------------------------------------------------------
module mgs_score #(
  parameter int CELLS_WIDE = 16,
  parameter int CELLS_HIGH = 12,
  localparam int TOTAL     = CELLS_WIDE * CELLS_HIGH,
  localparam int CNT_W     = $clog2(TOTAL + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      res_valid,
  output logic                      res_ready,
  input  logic [mgs_pkg::SUM_W-1:0] res_sum,
  input  logic [CNT_W-1:0]          res_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mgs_pkg::score_item_t      out_data
);

  localparam int SW    = mgs_pkg::SUM_W;
  localparam int QW    = mgs_pkg::QUOT_W;
  localparam int LOG_D = $clog2(TOTAL);
  // reciprocal of the cell count, exact for any 32-bit sum
  localparam int K1    = SW + LOG_D;
  localparam int M1_W  = SW + 1;
  localparam int P1_W  = SW + M1_W;
  localparam logic [M1_W-1:0] M1 =
    M1_W'(((64'd1 << K1) + 64'(TOTAL) - 64'd1) / 64'(TOTAL));
  // reciprocal again for remainder * unmarked, which stays below cells^2
  localparam int TW    = 2 * CNT_W;
  localparam int K2    = TW + LOG_D;
  localparam int M2_W  = TW + 1;
  localparam int P2_W  = TW + M2_W;
  localparam logic [M2_W-1:0] M2 =
    M2_W'(((64'd1 << K2) + 64'(TOTAL) - 64'd1) / 64'(TOTAL));

  logic             m_valid_r;
  logic [SW-1:0]    m_sum_r;
  logic [CNT_W-1:0] m_cnt_r;

  logic             s1_valid_r;
  logic [SW-1:0]    s1_sum_r;
  logic [SW-1:0]    s1_quo_r;
  logic [CNT_W-1:0] s1_cnt_r;

  logic             s2_valid_r;
  logic [SW-1:0]    s2_hi_r;
  logic [CNT_W-1:0] s2_rem_r;
  logic [CNT_W-1:0] s2_unm_r;
  logic [CNT_W-1:0] s2_cnt_r;

  logic             s3_valid_r;
  logic [SW-1:0]    s3_hi_r;
  logic [TW-1:0]    s3_frac_r;
  logic [CNT_W-1:0] s3_cnt_r;

  logic                 out_valid_r;
  mgs_pkg::score_item_t out_data_r;

  logic             out_adv;
  logic             s3_adv;
  logic             s2_adv;
  logic             s1_adv;
  logic             m_adv;
  logic [P1_W-1:0]  quo_prod;
  logic [SW-1:0]    quo;
  logic [CNT_W-1:0] unmarked;
  logic [SW-1:0]    quo_times_d;
  logic [SW-1:0]    rem_wide;
  logic [SW-1:0]    hi;
  logic [TW-1:0]    frac;
  logic [P2_W-1:0]  frac_prod;
  logic [SW-1:0]    score;

  // a stage moves when it is empty or the one after it moves
  assign out_adv   = !out_valid_r || out_ready;
  assign s3_adv    = !s3_valid_r || out_adv;
  assign s2_adv    = !s2_valid_r || s3_adv;
  assign s1_adv    = !s1_valid_r || s2_adv;
  assign m_adv     = !m_valid_r || s1_adv;
  assign res_ready = m_adv;

  // sum = quo * cells + rem, so score = quo * unmarked + rem * unmarked / cells
  assign quo_prod    = P1_W'(m_sum_r) * P1_W'(M1);
  assign quo         = SW'(quo_prod >> K1);
  assign unmarked    = CNT_W'(TOTAL) - s1_cnt_r;
  assign quo_times_d = s1_quo_r * SW'(TOTAL);
  assign rem_wide    = s1_sum_r - quo_times_d;
  assign hi          = s1_quo_r * SW'(unmarked);
  assign frac        = TW'(s2_rem_r) * TW'(s2_unm_r);
  assign frac_prod   = P2_W'(s3_frac_r) * P2_W'(M2);
  assign score       = s3_hi_r + SW'(frac_prod >> K2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r   <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (m_adv) begin
        m_valid_r <= res_valid;
      end
      if (s1_adv) begin
        s1_valid_r <= m_valid_r;
      end
      if (s2_adv) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_adv) begin
        s3_valid_r <= s2_valid_r;
      end
      if (out_adv) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_adv) begin
      m_sum_r <= res_sum;
      m_cnt_r <= res_count;
    end
    if (s1_adv) begin
      s1_sum_r <= m_sum_r;
      s1_quo_r <= quo;
      s1_cnt_r <= m_cnt_r;
    end
    if (s2_adv) begin
      s2_hi_r  <= hi;
      s2_rem_r <= CNT_W'(rem_wide);
      s2_unm_r <= unmarked;
      s2_cnt_r <= s1_cnt_r;
    end
    if (s3_adv) begin
      s3_hi_r   <= s2_hi_r;
      s3_frac_r <= frac;
      s3_cnt_r  <= s2_cnt_r;
    end
    if (out_adv) begin
      out_data_r.cells_with_motion <= mgs_pkg::CELLS_W'(s3_cnt_r);
      out_data_r.motion_score      <= QW'(score);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/motion_grid_score.sv */
// ----------------------------------------------------------------------------
// motion_grid_score
// Grid-cell motion score over a raster stream of 8-bit difference pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one pixel per item in raster order, with
//   last_of_frame set on the final pixel. Pixels are taken one per cycle
//   while in_ready is high; position updates in the cycle after acceptance;
//   cell marks, count and sum update from the input register. Only the last
//   pixel of a frame produces an item on out_valid/out_ready/out_data:
//   marked-cell count and floor(sum * unmarked / cells). That item passes
//   through the input register, the score input register, three scoring
//   stages (reciprocal divide, scale by unmarked cells, remainder product)
//   and the output register. Frames may follow back to back, down to one
//   pixel per frame. When the receiver stalls, results queue in the score
//   stages (five deep); in_ready drops only once every stage holds a
//   waiting result and another last pixel sits in the input register, so
//   pixels that end no frame keep flowing meanwhile.
//   cfg_we/cfg_wdata write the frame width (pixels per row) with no wait;
//   write it only while no frame result is pending.
//   Reset (rst_n low, synchronous) sets the frame width to 320, starts at
//   column 0, row 0 with no cells marked and a zero sum, and empties the
//   pipeline.
// ----------------------------------------------------------------------------
module motion_grid_score #(
  parameter int CELLS_WIDE = 16,
  parameter int CELLS_HIGH = 12,
  parameter int CELL_SIZE  = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mgs_pkg::pixel_item_t      in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mgs_pkg::score_item_t      out_data,
  input  logic                      cfg_we,
  input  logic [mgs_pkg::POS_W-1:0] cfg_wdata
);

  localparam int TOTAL = CELLS_WIDE * CELLS_HIGH;
  localparam int IDX_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int CNT_W = $clog2(TOTAL + 1);

  logic [mgs_pkg::POS_W-1:0] frame_width_r;
  logic                      in_fire;
  logic                      loc_in_grid;
  logic [IDX_W-1:0]          loc_idx;
  logic                      res_valid;
  logic                      res_ready;
  logic [mgs_pkg::SUM_W-1:0] res_sum;
  logic [CNT_W-1:0]          res_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= mgs_pkg::FRAME_WIDTH_RESET;
    end else if (cfg_we) begin
      frame_width_r <= cfg_wdata;
    end
  end

  assign in_fire = in_valid && in_ready;

  mgs_pos #(
    .CELLS_WIDE (CELLS_WIDE),
    .CELLS_HIGH (CELLS_HIGH),
    .CELL_SIZE  (CELL_SIZE)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_fire   (in_fire),
    .item_last   (in_data.last_of_frame),
    .frame_width (frame_width_r),
    .loc_in_grid (loc_in_grid),
    .loc_idx     (loc_idx)
  );

  mgs_accum #(
    .CELLS_WIDE (CELLS_WIDE),
    .CELLS_HIGH (CELLS_HIGH)
  ) u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .loc_in_grid (loc_in_grid),
    .loc_idx     (loc_idx),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_sum     (res_sum),
    .res_count   (res_count)
  );

  mgs_score #(
    .CELLS_WIDE (CELLS_WIDE),
    .CELLS_HIGH (CELLS_HIGH)
  ) u_score (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_sum   (res_sum),
    .res_count (res_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a new frame always starts in the top-left cell
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last_of_frame |=> loc_in_grid && (loc_idx == '0))
    else $error("position not restarted after last pixel");

  // input backpressure only comes from a full, stalled score pipeline
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without a stalled result");

  // the marked count handed to scoring never exceeds the cell count
  assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |-> res_count <= CNT_W'(TOTAL))
    else $error("marked count exceeds cell count");

endmodule
